### sv/nhes_pkg.sv
// Shared types, constants and helpers of the NAL header and emulation strip block.
package nhes_pkg;

  // NAL unit types that carry an extension header after byte 0
  localparam logic [4:0] TYPE_PREFIX    = 5'd14;
  localparam logic [4:0] TYPE_SLICE_EXT = 5'd20;
  localparam logic [4:0] TYPE_DEPTH_EXT = 5'd21;

  // Emulation prevention byte that ends the 0x000003 pattern
  localparam logic [7:0] EPB_BYTE = 8'h03;

  // Position counter saturates here
  localparam logic [2:0] POS_MAX = 3'd4;

  // Header lengths in bytes
  localparam logic [2:0] HDR_LEN_BASE  = 3'd1;
  localparam logic [2:0] HDR_LEN_SHORT = 3'd3;
  localparam logic [2:0] HDR_LEN_LONG  = 3'd4;

  // Zero run counter saturates at two
  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       unit_end;
    logic       forbidden_bit;
    logic [1:0] ref_level;
    logic [4:0] unit_type;
    logic       extension_flag;
    logic [2:0] header_length;
  } result_t;

  function automatic logic has_ext_header(input logic [4:0] unit_type);
    return (unit_type == TYPE_PREFIX) || (unit_type == TYPE_SLICE_EXT) ||
           (unit_type == TYPE_DEPTH_EXT);
  endfunction

endpackage

### sv/nhes_parse.sv
// Per-unit parse state and the single-pass header/payload decision for one byte.
module nhes_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             first_of_unit_i,
  input  logic             last_of_unit_i,
  output nhes_pkg::result_t result_o
);

  logic [2:0] byte_position_q, byte_position_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic       forbidden_q, forbidden_d;
  logic [1:0] ref_level_q, ref_level_d;
  logic [4:0] type_q, type_d;
  logic       extension_q, extension_d;
  logic [2:0] hdr_len_q, hdr_len_d;

  logic [2:0] pos;
  logic       pay_valid;
  logic [7:0] pay_byte;

  always_comb begin
    pos          = first_of_unit_i ? 3'd0 : byte_position_q;
    zero_run_d   = zero_run_q;
    forbidden_d  = forbidden_q;
    ref_level_d  = ref_level_q;
    type_d       = type_q;
    extension_d  = extension_q;
    hdr_len_d    = hdr_len_q;
    pay_valid    = 1'b0;
    pay_byte     = 8'd0;

    if (pos == 3'd0) begin
      // header byte 0: latch the unit's fields
      forbidden_d = data_byte_i[7];
      ref_level_d = data_byte_i[6:5];
      type_d      = data_byte_i[4:0];
      extension_d = 1'b0;
      hdr_len_d   = nhes_pkg::has_ext_header(data_byte_i[4:0]) ?
                    nhes_pkg::HDR_LEN_LONG : nhes_pkg::HDR_LEN_BASE;
      zero_run_d  = 2'd0;
    end else if (pos == 3'd1 && nhes_pkg::has_ext_header(type_q)) begin
      extension_d = data_byte_i[7];
      if (type_q == nhes_pkg::TYPE_DEPTH_EXT) begin
        hdr_len_d = data_byte_i[7] ? nhes_pkg::HDR_LEN_SHORT : nhes_pkg::HDR_LEN_LONG;
      end
    end else if (pos >= hdr_len_q) begin
      if (zero_run_q == nhes_pkg::ZERO_RUN_MAX && data_byte_i == nhes_pkg::EPB_BYTE) begin
        // drop the emulation prevention byte, restart the zero count
        zero_run_d = 2'd0;
      end else begin
        pay_valid = 1'b1;
        pay_byte  = data_byte_i;
        if (data_byte_i == 8'd0) begin
          zero_run_d = (zero_run_q == nhes_pkg::ZERO_RUN_MAX) ?
                       nhes_pkg::ZERO_RUN_MAX : zero_run_q + 2'd1;
        end else begin
          zero_run_d = 2'd0;
        end
      end
    end

    if (last_of_unit_i) begin
      byte_position_d = 3'd0;
    end else begin
      byte_position_d = (pos < nhes_pkg::POS_MAX) ? pos + 3'd1 : nhes_pkg::POS_MAX;
    end

    result_o.payload_valid  = pay_valid;
    result_o.payload_byte   = pay_byte;
    result_o.unit_end       = last_of_unit_i;
    result_o.forbidden_bit  = forbidden_d;
    result_o.ref_level      = ref_level_d;
    result_o.unit_type      = type_d;
    result_o.extension_flag = extension_d;
    result_o.header_length  = hdr_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= 3'd0;
      zero_run_q      <= 2'd0;
      forbidden_q     <= 1'b0;
      ref_level_q     <= 2'd0;
      type_q          <= 5'd0;
      extension_q     <= 1'b0;
      hdr_len_q       <= nhes_pkg::HDR_LEN_BASE;
    end else if (step_i) begin
      byte_position_q <= byte_position_d;
      zero_run_q      <= zero_run_d;
      forbidden_q     <= forbidden_d;
      ref_level_q     <= ref_level_d;
      type_q          <= type_d;
      extension_q     <= extension_d;
      hdr_len_q       <= hdr_len_d;
    end
  end

endmodule

### sv/nal_header_and_emulation_strip.sv
// Top level of the NAL header parser and emulation prevention byte remover.
//
// Takes a NAL unit one byte per item and returns one result item per byte.
// Header byte 0 gives the forbidden bit, reference level and unit type; types
// 14 and 20 carry a 4-byte header, type 21 a 3-byte header when the top bit of
// byte 1 is set and 4 bytes otherwise, all others 1 byte. Header bytes come
// out with payload_valid low. Payload bytes pass through, except that a 0x03
// following two or more zero payload bytes is dropped (payload_valid low,
// payload_byte zero). The header fields on each result show the unit's values
// as known after that byte. A byte with first_of_unit, or any byte after a
// byte with last_of_unit (or the first after reset), starts a new unit.
// Throughput is one item per clock cycle while out_ready_i keeps results
// draining. An accepted item is held in the input register until the result
// register is free or drains; the parse logic and state update then feed
// the result register. The result register and the input register are parted
// so a new item is taken while a result waits.
module nal_header_and_emulation_strip (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_unit_i,
  input  logic       last_of_unit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       unit_end_o,
  output logic       forbidden_bit_o,
  output logic [1:0] ref_level_o,
  output logic [4:0] unit_type_o,
  output logic       extension_flag_o,
  output logic [2:0] header_length_o
);

  // Input register stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // Result register stage
  logic              out_valid_q;
  nhes_pkg::result_t out_q;
  nhes_pkg::result_t res;

  logic advance;

  // Move the held item into the result register when that slot is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload of the input stage: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= data_byte_i;
      in_first_q <= first_of_unit_i;
      in_last_q  <= last_of_unit_i;
    end
  end

  // Parse state advances exactly once per item, as it enters the result stage
  nhes_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (in_byte_q),
    .first_of_unit_i (in_first_q),
    .last_of_unit_i  (in_last_q),
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign unit_end_o       = out_q.unit_end;
  assign forbidden_bit_o  = out_q.forbidden_bit;
  assign ref_level_o      = out_q.ref_level;
  assign unit_type_o      = out_q.unit_type;
  assign extension_flag_o = out_q.extension_flag;
  assign header_length_o  = out_q.header_length;

endmodule

### sv/nhes_checker.sv
// Port-level checker for the NAL header strip block and its bind statement.
module nhes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       first_of_unit_i,
  input logic       last_of_unit_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       payload_valid_o,
  input logic [7:0] payload_byte_o,
  input logic       unit_end_o,
  input logic       forbidden_bit_o,
  input logic [1:0] ref_level_o,
  input logic [4:0] unit_type_o,
  input logic       extension_flag_o,
  input logic [2:0] header_length_o
);

  // Offered input item holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i) &&
    $stable(first_of_unit_i) && $stable(last_of_unit_i))
    else $error("input item changed while stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o) &&
    $stable(payload_valid_o) && $stable(unit_end_o) && $stable(header_length_o) &&
    $stable(forbidden_bit_o) && $stable(ref_level_o) && $stable(unit_type_o) &&
    $stable(extension_flag_o))
    else $error("result changed while stalled");

  // Dropped or header byte carries zero
  a_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'd0)
    else $error("non-payload result carries data");

  // Extension flag only on extension types
  a_ext_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && extension_flag_o |->
    (unit_type_o == nhes_pkg::TYPE_PREFIX || unit_type_o == nhes_pkg::TYPE_SLICE_EXT ||
     unit_type_o == nhes_pkg::TYPE_DEPTH_EXT))
    else $error("extension flag on plain unit type");

  // Header length agrees with type and extension flag
  a_hdr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
    (header_length_o == nhes_pkg::HDR_LEN_SHORT &&
     unit_type_o == nhes_pkg::TYPE_DEPTH_EXT && extension_flag_o) ||
    (header_length_o == nhes_pkg::HDR_LEN_LONG &&
     (unit_type_o == nhes_pkg::TYPE_PREFIX || unit_type_o == nhes_pkg::TYPE_SLICE_EXT ||
      unit_type_o == nhes_pkg::TYPE_DEPTH_EXT)) ||
    (header_length_o == nhes_pkg::HDR_LEN_BASE &&
     unit_type_o != nhes_pkg::TYPE_PREFIX && unit_type_o != nhes_pkg::TYPE_SLICE_EXT &&
     unit_type_o != nhes_pkg::TYPE_DEPTH_EXT))
    else $error("header length does not match unit type");

endmodule

bind nal_header_and_emulation_strip nhes_checker u_nhes_checker (.*);

### test/tb_nal_header_and_emulation_strip.sv
// Testbench for the NAL header parser and emulation prevention byte remover.
`timescale 1ns / 1ps

module tb_nal_header_and_emulation_strip;

  localparam int RANDOM_BYTES    = 550;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } nal_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       first_of_unit_i = 1'b0;
  logic       last_of_unit_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic       payload_valid_o;
  logic [7:0] payload_byte_o;
  logic       unit_end_o;
  logic       forbidden_bit_o;
  logic [1:0] ref_level_o;
  logic [4:0] unit_type_o;
  logic       extension_flag_o;
  logic [2:0] header_length_o;

  nal_header_and_emulation_strip dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_of_unit_i  (first_of_unit_i),
    .last_of_unit_i   (last_of_unit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .unit_end_o       (unit_end_o),
    .forbidden_bit_o  (forbidden_bit_o),
    .ref_level_o      (ref_level_o),
    .unit_type_o      (unit_type_o),
    .extension_flag_o (extension_flag_o),
    .header_length_o  (header_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset at start, then release it; it is never asserted again.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: its own copy of the unit state, advanced once per accepted
  // byte. Starts from the reset values of the block.
  // ---------------------------------------------------------------------------
  logic [2:0] unit_pos      = '0;
  logic [1:0] zero_count    = '0;
  logic       hdr_forbidden = 1'b0;
  logic [1:0] hdr_ref       = '0;
  logic [4:0] hdr_type      = '0;
  logic       hdr_ext       = 1'b0;
  logic [2:0] hdr_len       = nhes_pkg::HDR_LEN_BASE;

  nal_byte_t         pending_bytes[$];
  nhes_pkg::result_t expected_results[$];

  int  bytes_accepted = 0;
  int  results_seen   = 0;
  int  mismatches     = 0;
  int  idle_cycles    = 0;
  int  send_gap       = 0;
  int  send_calm      = 0;
  int  recv_stall     = 0;
  int  recv_calm      = 0;
  bit  unit_left_open = 1'b0;

  nal_byte_t         next_byte;
  nhes_pkg::result_t seen_result;
  nhes_pkg::result_t wanted_result;

  function automatic bit is_ext_type(input logic [4:0] t);
    return t == nhes_pkg::TYPE_PREFIX || t == nhes_pkg::TYPE_SLICE_EXT ||
           t == nhes_pkg::TYPE_DEPTH_EXT;
  endfunction

  // Work out the result of one byte and advance the shadow state.
  function automatic nhes_pkg::result_t parse_nal_byte(input logic [7:0] b,
                                                       input logic first,
                                                       input logic last);
    nhes_pkg::result_t r;
    logic [2:0]        pos;
    r = '0;
    if (first) unit_pos = '0;
    pos = unit_pos;

    if (pos == 3'd0) begin
      // header byte 0: latch the unit fields, forget any zero run
      hdr_forbidden = b[7];
      hdr_ref       = b[6:5];
      hdr_type      = b[4:0];
      hdr_ext       = 1'b0;
      hdr_len       = is_ext_type(b[4:0]) ? nhes_pkg::HDR_LEN_LONG : nhes_pkg::HDR_LEN_BASE;
      zero_count    = '0;
    end else if (pos == 3'd1 && is_ext_type(hdr_type)) begin
      hdr_ext = b[7];
      if (hdr_type == nhes_pkg::TYPE_DEPTH_EXT)
        hdr_len = b[7] ? nhes_pkg::HDR_LEN_SHORT : nhes_pkg::HDR_LEN_LONG;
    end else if (pos >= hdr_len) begin
      if (zero_count >= nhes_pkg::ZERO_RUN_MAX && b == nhes_pkg::EPB_BYTE) begin
        // drop the emulation prevention byte and restart the zero count
        zero_count = '0;
      end else begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        if (b == 8'h00) begin
          zero_count = (zero_count < nhes_pkg::ZERO_RUN_MAX) ?
                       zero_count + 2'd1 : nhes_pkg::ZERO_RUN_MAX;
        end else begin
          zero_count = '0;
        end
      end
    end

    unit_pos = last ? 3'd0 : ((pos < nhes_pkg::POS_MAX) ? pos + 3'd1 : nhes_pkg::POS_MAX);

    r.unit_end       = last;
    r.forbidden_bit  = hdr_forbidden;
    r.ref_level      = hdr_ref;
    r.unit_type      = hdr_type;
    r.extension_flag = hdr_ext;
    r.header_length  = hdr_len;
    return r;
  endfunction

  // Gap lengths: mostly none or short, a few long, and now and then a calm
  // stretch with no gaps at all.
  function automatic int draw_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic first, input logic last);
    pending_bytes.push_back('{data: data, first: first, last: last});
  endtask

  // One random unit: a header of the right shape for its type, then a payload
  // rich in zeros and 0x03 so that the stripping logic gets exercised. A few
  // units end inside the header, a few never end and are cut by the next start.
  task automatic queue_random_unit();
    logic [7:0] unit_bytes[$];
    logic [7:0] head;
    int         payload_len;
    int         cut;
    int         k;
    int         pick;
    bit         open_end;
    bit         mark_first;
    head = 8'($urandom);
    if ($urandom_range(0, 99) < 50) begin
      pick = $urandom_range(0, 2);
      head[4:0] = (pick == 0) ? nhes_pkg::TYPE_PREFIX :
                  (pick == 1) ? nhes_pkg::TYPE_SLICE_EXT : nhes_pkg::TYPE_DEPTH_EXT;
    end
    unit_bytes.push_back(head);
    // three more header bytes; for a 3-byte header the last one is payload
    if (is_ext_type(head[4:0])) repeat (3) unit_bytes.push_back(8'($urandom));
    payload_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (payload_len) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      unit_bytes.push_back(8'h00);
      else if (pick < 70) unit_bytes.push_back(nhes_pkg::EPB_BYTE);
      else                unit_bytes.push_back(8'($urandom));
    end
    cut = unit_bytes.size();
    if ($urandom_range(0, 99) < 8) cut = $urandom_range(1, (cut < 3) ? cut : 3);
    open_end   = ($urandom_range(0, 99) < 8);
    mark_first = unit_left_open || ($urandom_range(0, 99) < 75);
    for (k = 0; k < cut; k++) begin
      queue_byte(unit_bytes[k], (k == 0) && mark_first, (k == cut - 1) && !open_end);
    end
    unit_left_open = open_end;
  endtask

  task automatic report_field(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("result %0d: %s expected %0h got %0h", results_seen, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next pending byte, hold it until accepted, then idle
  // for a random gap. Predict each byte at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(parse_nal_byte(data_byte_i, first_of_unit_i,
                                                  last_of_unit_i));
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_byte       = pending_bytes.pop_front();
          data_byte_i     <= next_byte.data;
          first_of_unit_i <= next_byte.first;
          last_of_unit_i  <= next_byte.last;
          in_valid_i      <= 1'b1;
          send_gap        = draw_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction, field
  // by field, then pick the next stall. Twice in the run hold off for a long
  // stretch so the block fills and pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_result = {payload_valid_o, payload_byte_o, unit_end_o, forbidden_bit_o,
                       ref_level_o, unit_type_o, extension_flag_o, header_length_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d: none expected, got %h", results_seen, seen_result);
          end
        end else begin
          wanted_result = expected_results.pop_front();
          if (seen_result.payload_valid !== wanted_result.payload_valid)
            report_field("payload_valid", wanted_result.payload_valid, seen_result.payload_valid);
          if (seen_result.payload_byte !== wanted_result.payload_byte)
            report_field("payload_byte", wanted_result.payload_byte, seen_result.payload_byte);
          if (seen_result.unit_end !== wanted_result.unit_end)
            report_field("unit_end", wanted_result.unit_end, seen_result.unit_end);
          if (seen_result.forbidden_bit !== wanted_result.forbidden_bit)
            report_field("forbidden_bit", wanted_result.forbidden_bit, seen_result.forbidden_bit);
          if (seen_result.ref_level !== wanted_result.ref_level)
            report_field("ref_level", wanted_result.ref_level, seen_result.ref_level);
          if (seen_result.unit_type !== wanted_result.unit_type)
            report_field("unit_type", wanted_result.unit_type, seen_result.unit_type);
          if (seen_result.extension_flag !== wanted_result.extension_flag)
            report_field("extension_flag", wanted_result.extension_flag,
                         seen_result.extension_flag);
          if (seen_result.header_length !== wanted_result.header_length)
            report_field("header_length", wanted_result.header_length,
                         seen_result.header_length);
        end
        if (results_seen == 150 || results_seen == 420) recv_stall = HOLD_OFF_CYCLES;
        else recv_stall = draw_gap(recv_calm);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_nal_header_and_emulation_strip failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int directed_bytes;

    // one-byte unit with every header bit set
    queue_byte(8'hFF, 1'b1, 1'b1);
    // type 0: a run of three zeros, then 0x03 dropped, then 0x03 kept
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(nhes_pkg::EPB_BYTE, 1'b0, 1'b0);
    queue_byte(nhes_pkg::EPB_BYTE, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    // type 21, extension set: 3-byte header, unit started without first flag
    queue_byte(8'h75, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h12, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    // type 21, extension clear: 4-byte header; zeros in it do not arm the drop
    queue_byte(8'h15, 1'b1, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(nhes_pkg::EPB_BYTE, 1'b0, 1'b1);
    // type 14 ending inside its header
    queue_byte(8'h0E, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b1);
    // type 20 with forbidden bit, cut off by a new unit start
    queue_byte(8'h94, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h41, 1'b1, 1'b1);
    directed_bytes = pending_bytes.size();

    while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) queue_random_unit();
    directed_bytes = pending_bytes.size();

    // wait for every byte to go in and every result to come out, then drain
    wait (bytes_accepted == directed_bytes);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_nal_header_and_emulation_strip passed");
    end else begin
      $display("tb_nal_header_and_emulation_strip failed");
    end
    $finish;
  end

endmodule

### nal_header_and_emulation_strip.f
sv/nhes_pkg.sv
sv/nhes_parse.sv
sv/nal_header_and_emulation_strip.sv
sv/nhes_checker.sv
test/tb_nal_header_and_emulation_strip.sv
